FILE: rtl/core/serial_attribute_video_generator_defines.svh
// ----------------------------------------------------------------------------
// Serial attribute video generator: assertion macros
// Shared concurrent assertion forms, clocked on clk and off during reset.
// ----------------------------------------------------------------------------
`ifndef SERIAL_ATTRIBUTE_VIDEO_GENERATOR_DEFINES_SVH
`define SERIAL_ATTRIBUTE_VIDEO_GENERATOR_DEFINES_SVH

// Same-cycle implication.
`define SAVG_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SAVG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/savg_pkg.sv
// ----------------------------------------------------------------------------
// savg_pkg
// Types and constants shared by the serial attribute video generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package savg_pkg;

    localparam int CELLS_PER_LINE = 40;
    localparam logic [5:0] LAST_COLUMN_LIMIT = 6'(CELLS_PER_LINE);
    localparam logic [15:0] ALT_CHARSET_OFFSET = 16'(128 * 8);

    // Request actions
    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_SCREEN = 2'd1;
    localparam logic [1:0] ACT_GLYPH  = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_GLYPH  = 2'd2;

    // Attribute groups, byte bits 4:3
    localparam logic [1:0] ATTR_FG   = 2'd0;
    localparam logic [1:0] ATTR_TEXT = 2'd1;
    localparam logic [1:0] ATTR_BG   = 2'd2;
    localparam logic [1:0] ATTR_MODE = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_LINES_PER_FRAME    = 3'd0;
    localparam logic [2:0] CFG_FIRST_VISIBLE_LINE = 3'd1;
    localparam logic [2:0] CFG_TEXT_ONLY_LINE     = 3'd2;
    localparam logic [2:0] CFG_END_VISIBLE_LINE   = 3'd3;
    localparam logic [2:0] CFG_HIRES_SCREEN_BASE  = 3'd4;
    localparam logic [2:0] CFG_HIRES_CHARSET_BASE = 3'd5;
    localparam logic [2:0] CFG_TEXT_SCREEN_BASE   = 3'd6;
    localparam logic [2:0] CFG_TEXT_CHARSET_BASE  = 3'd7;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] fetch_address;
        logic [2:0]  fg_out;
        logic [2:0]  bg_out;
        logic [5:0]  pattern;
        logic        visible_line;
        logic        frame_start;
        logic        last_cell;
    } rsp_t;

endpackage

FILE: rtl/core/savg_engine.sv
// ----------------------------------------------------------------------------
// savg_engine
// Configuration registers, raster and attribute state, and the
// combinational decode of a request into its result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module savg_engine (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  savg_pkg::req_t req,
    input  logic           cfg_we,
    input  logic [2:0]     cfg_index,
    input  logic [15:0]    cfg_data,
    output savg_pkg::rsp_t rsp
);
    import savg_pkg::*;

    logic [8:0]  lines_per_frame_reg, first_visible_line_reg;
    logic [8:0]  text_only_line_reg, end_visible_line_reg;
    logic [15:0] hires_screen_base_reg, hires_charset_base_reg;
    logic [15:0] text_screen_base_reg, text_charset_base_reg;

    logic [8:0] raster_line_reg, raster_line_next;
    logic [4:0] frame_count_reg, frame_count_next;
    logic [5:0] cell_column_reg, cell_column_next;
    logic [2:0] fg_colour_reg, fg_colour_next;
    logic [2:0] bg_colour_reg, bg_colour_next;
    logic [2:0] text_attributes_reg, text_attributes_next;
    logic [2:0] display_mode_reg, display_mode_next;
    logic       pending_inverse_reg, pending_inverse_next;
    logic       glyph_pending_reg, glyph_pending_next;

    function automatic logic in_window(input logic [8:0] line);
        return (line >= first_visible_line_reg) && (line < end_visible_line_reg);
    endfunction

    function automatic logic [15:0] screen_address(input logic [8:0] line,
                                                   input logic [5:0] col,
                                                   input logic [2:0] mode);
        logic [8:0]  y;
        logic [15:0] row_index;
        y = line - first_visible_line_reg;
        if ((line < text_only_line_reg) && mode[2])
        begin
            row_index = {7'd0, y};
            return hires_screen_base_reg + {10'd0, col}
                   + (row_index * 16'(CELLS_PER_LINE));
        end
        row_index = {10'd0, y[8:3]};
        return text_screen_base_reg + {10'd0, col} + (row_index * 16'(CELLS_PER_LINE));
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lines_per_frame_reg    <= 9'd312;
            first_visible_line_reg <= 9'd65;
            text_only_line_reg     <= 9'd265;
            end_visible_line_reg   <= 9'd289;
            hires_screen_base_reg  <= 16'hA000;
            hires_charset_base_reg <= 16'h9800;
            text_screen_base_reg   <= 16'hBB80;
            text_charset_base_reg  <= 16'hB400;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LINES_PER_FRAME:    lines_per_frame_reg    <= cfg_data[8:0];
                CFG_FIRST_VISIBLE_LINE: first_visible_line_reg <= cfg_data[8:0];
                CFG_TEXT_ONLY_LINE:     text_only_line_reg     <= cfg_data[8:0];
                CFG_END_VISIBLE_LINE:   end_visible_line_reg   <= cfg_data[8:0];
                CFG_HIRES_SCREEN_BASE:  hires_screen_base_reg  <= cfg_data;
                CFG_HIRES_CHARSET_BASE: hires_charset_base_reg <= cfg_data;
                CFG_TEXT_SCREEN_BASE:   text_screen_base_reg   <= cfg_data;
                CFG_TEXT_CHARSET_BASE:  text_charset_base_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raster_line_reg     <= '0;
            frame_count_reg     <= '0;
            cell_column_reg     <= '0;
            fg_colour_reg       <= 3'd7;
            bg_colour_reg       <= '0;
            text_attributes_reg <= '0;
            display_mode_reg    <= '0;
            pending_inverse_reg <= 1'b0;
            glyph_pending_reg   <= 1'b0;
        end
        else if (accept)
        begin
            raster_line_reg     <= raster_line_next;
            frame_count_reg     <= frame_count_next;
            cell_column_reg     <= cell_column_next;
            fg_colour_reg       <= fg_colour_next;
            bg_colour_reg       <= bg_colour_next;
            text_attributes_reg <= text_attributes_next;
            display_mode_reg    <= display_mode_next;
            pending_inverse_reg <= pending_inverse_next;
            glyph_pending_reg   <= glyph_pending_next;
        end
    end

    logic [9:0]  line_inc;
    logic        wrap;
    logic [8:0]  tick_line;
    logic        tick_visible;
    logic        cur_visible;
    logic [8:0]  win_y;
    logic [2:0]  glyph_row;
    logic [15:0] glyph_base;
    logic [5:0]  blink_mask;
    logic        is_attr;
    logic        cell_inv;
    logic [5:0]  col_inc;
    logic        col_last;
    logic [5:0]  cell_pattern;

    always_comb
    begin
        line_inc     = {1'b0, raster_line_reg} + 10'd1;
        wrap         = line_inc[9] || (line_inc >= {1'b0, lines_per_frame_reg});
        tick_line    = wrap ? 9'd0 : line_inc[8:0];
        tick_visible = in_window(tick_line);
        cur_visible  = in_window(raster_line_reg);
        win_y        = raster_line_reg - first_visible_line_reg;
        glyph_row    = text_attributes_reg[1] ? win_y[3:1] : win_y[2:0];
        glyph_base   = display_mode_reg[2] ? hires_charset_base_reg : text_charset_base_reg;
        blink_mask   = (frame_count_reg[4] || !text_attributes_reg[2]) ? 6'h3f : 6'h00;
        is_attr      = (req.data[6:5] == 2'b00);
        col_inc      = cell_column_reg + 6'd1;
        col_last     = (col_inc >= LAST_COLUMN_LIMIT);

        raster_line_next     = raster_line_reg;
        frame_count_next     = frame_count_reg;
        cell_column_next     = cell_column_reg;
        fg_colour_next       = fg_colour_reg;
        bg_colour_next       = bg_colour_reg;
        text_attributes_next = text_attributes_reg;
        display_mode_next    = display_mode_reg;
        pending_inverse_next = pending_inverse_reg;
        glyph_pending_next   = glyph_pending_reg;

        cell_inv     = 1'b0;
        cell_pattern = '0;

        rsp               = '0;
        rsp.kind          = KIND_STATUS;
        rsp.visible_line  = cur_visible;

        unique case (req.action)
            ACT_TICK:
            begin
                raster_line_next   = tick_line;
                cell_column_next   = '0;
                glyph_pending_next = 1'b0;
                if (wrap)
                begin
                    frame_count_next = frame_count_reg + 5'd1;
                end
                if (tick_visible)
                begin
                    fg_colour_next       = 3'd7;
                    bg_colour_next       = '0;
                    text_attributes_next = '0;
                    rsp.fetch_address    = screen_address(tick_line, 6'd0, display_mode_reg);
                end
                rsp.visible_line = tick_visible;
                rsp.frame_start  = wrap;
            end
            ACT_SCREEN:
            begin
                if (cur_visible && (cell_column_reg < LAST_COLUMN_LIMIT) && !glyph_pending_reg)
                begin
                    cell_inv = req.data[7];
                    if (is_attr)
                    begin
                        case (req.data[4:3])
                            ATTR_FG:   fg_colour_next       = req.data[2:0];
                            ATTR_TEXT: text_attributes_next = req.data[2:0];
                            ATTR_BG:   bg_colour_next       = req.data[2:0];
                            default:   display_mode_next    = req.data[2:0];
                        endcase
                        rsp.kind = KIND_PIXEL;
                    end
                    else if ((raster_line_reg < text_only_line_reg) && display_mode_reg[2])
                    begin
                        cell_pattern = req.data[5:0] & blink_mask;
                        rsp.kind     = KIND_PIXEL;
                    end
                    else
                    begin
                        glyph_pending_next   = 1'b1;
                        pending_inverse_next = req.data[7];
                        rsp.kind             = KIND_GLYPH;
                        rsp.fetch_address    = glyph_base
                            + (text_attributes_reg[0] ? ALT_CHARSET_OFFSET : 16'd0)
                            + {6'd0, req.data[6:0], glyph_row};
                    end
                end
            end
            ACT_GLYPH:
            begin
                if (glyph_pending_reg)
                begin
                    glyph_pending_next = 1'b0;
                    cell_inv           = pending_inverse_reg;
                    cell_pattern       = req.data[5:0] & blink_mask;
                    rsp.kind           = KIND_PIXEL;
                end
            end
            default: ;
        endcase

        // Finish a cell: colours after any attribute decode, then advance.
        if (rsp.kind == KIND_PIXEL)
        begin
            cell_column_next  = col_inc;
            rsp.fg_out        = fg_colour_next ^ {3{cell_inv}};
            rsp.bg_out        = bg_colour_next ^ {3{cell_inv}};
            rsp.pattern       = cell_pattern;
            rsp.last_cell     = col_last;
            rsp.fetch_address = col_last ? 16'd0
                : screen_address(raster_line_reg, col_inc, display_mode_next);
        end
    end

endmodule

FILE: rtl/core/serial_attribute_video_generator.sv
// ----------------------------------------------------------------------------
// Serial attribute video generator
// Usage:
//   Requests enter on req (action, data) under req_valid / req_ready. Each
//   request yields exactly one result on rsp under rsp_valid / rsp_ready:
//   a line status, six pixels of a cell, or a glyph row fetch request.
//   A request's result is registered at its accepting edge, into rsp if
//   free. Throughput is one request per cycle while req_ready is high, set
//   by the single decode stage between state registers and result register.
//   When the receiver stalls, one more result is held in a skid register;
//   req_ready drops only while that skid register is full, so at most two
//   results wait. Configuration goes in through cfg_we / cfg_index /
//   cfg_data, taken at any edge with cfg_we high, and should be written only
//   while no request is in flight. Reset (rst_n low, asynchronous) loads the
//   default register values, clears the raster counters and the pending
//   glyph, sets white on black, and empties both result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_attribute_video_generator (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  savg_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output savg_pkg::rsp_t rsp,
    input  logic           cfg_we,
    input  logic [2:0]     cfg_index,
    input  logic [15:0]    cfg_data
);
    import savg_pkg::*;

    `include "serial_attribute_video_generator_defines.svh"

    logic accept;
    rsp_t step_rsp;

    rsp_t out_reg;
    logic out_valid_reg;
    rsp_t skid_reg;
    logic skid_valid_reg;
    logic pop;

    // Take a request whenever the skid slot is free.
    assign req_ready = !skid_valid_reg;
    assign accept    = req_valid && req_ready;
    assign pop       = out_valid_reg && rsp_ready;

    savg_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp       (step_rsp)
    );

    // Output register plus skid: advance skid into the output on a pop,
    // otherwise land a new result in whichever slot is free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (skid_valid_reg)
                begin
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= accept;
                end
            end
            else if (!out_valid_reg)
            begin
                out_valid_reg <= accept;
            end
            else if (accept)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
        else if (accept && (pop || !out_valid_reg))
        begin
            out_reg <= step_rsp;
        end
        if (accept && out_valid_reg && !pop)
        begin
            skid_reg <= step_rsp;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    `SAVG_ASSERT_HOLDS(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid full, output empty")
    `SAVG_ASSERT_NEXT(a_empty_push_lands, accept && !out_valid_reg, out_valid_reg, "result lost")
    `SAVG_ASSERT_HOLDS(a_frame_on_status, rsp_valid && rsp.frame_start, rsp.kind == KIND_STATUS, "frame_start on non-status result")
    `SAVG_ASSERT_HOLDS(a_last_cell_form, rsp_valid && rsp.last_cell, (rsp.kind == KIND_PIXEL) && (rsp.fetch_address == 16'd0), "bad last cell result")

endmodule
